// ----- rtl/bicpc_pkg.sv -----
// ----------------------------------------------------------------------------
// Coast pixel counter package
// Sizes, register indexes and helper functions shared by the counter and its
// checker.
// ----------------------------------------------------------------------------
package bicpc_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    localparam int CFG_W   = 11;
    localparam int COUNT_W = 21;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam int COL_AW = $clog2(MAX_COLS);
    localparam int ROW_AW = $clog2(MAX_ROWS);

    typedef logic [COL_AW-1:0]  col_t;
    typedef logic [ROW_AW-1:0]  row_t;
    typedef logic [CFG_W-1:0]   cfg_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam count_t COUNT_MAX = '1;

    // Register index, taken from the word address bit of the APB port.
    typedef enum logic
    {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } reg_idx_t;

    // Index of the last column, after the configured width has been clamped
    // into the range one to MAX_COLS.
    function automatic col_t last_col(input cfg_t v);
        col_t r;
        if (v == '0)
        begin
            r = '0;
        end
        else if (int'(v) > MAX_COLS)
        begin
            r = col_t'(MAX_COLS - 1);
        end
        else
        begin
            r = col_t'(int'(v) - 1);
        end
        return r;
    endfunction

    // Index of the last row, clamped in the same way.
    function automatic row_t last_row(input cfg_t v);
        row_t r;
        if (v == '0)
        begin
            r = '0;
        end
        else if (int'(v) > MAX_ROWS)
        begin
            r = row_t'(MAX_ROWS - 1);
        end
        else
        begin
            r = row_t'(int'(v) - 1);
        end
        return r;
    endfunction

endpackage

// ----- rtl/binary_image_coast_pixel_count_top.sv -----
// ----------------------------------------------------------------------------
// Binary image coast pixel counter
// Counts the land pixels of a raster-order binary image that lie on the image
// border or touch water through one of their four neighbours.
// ----------------------------------------------------------------------------

// The block takes one pixel item per clock cycle in raster order (1 is land,
// 0 is water) and, after the last pixel of a frame, delivers a single result
// item holding the number of coast pixels in that frame. The frame size comes
// from the image_rows and image_cols registers (APB, byte addresses 0 and 4);
// a value of zero is treated as one and values above the maximum line length
// or height are clamped to it. Any register write restarts the frame. The
// sustained rate is one pixel per cycle: the only loop is the registered update
// of the column and row counters and of the running count, and the line store
// is a single memory with one write and one read port per cycle. The only time
// the input stalls is when the last pixel of a frame arrives while the result
// of the previous frame has not yet been taken. No clearing pass is needed
// after reset, since line store contents are only used once the current frame
// has written them.
module binary_image_coast_pixel_count_top
(
    input  logic                          clk,
    input  logic                          rst_n,

    // Pixel input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          is_land,

    // Result output
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bicpc_pkg::COUNT_W-1:0] coast_count,

    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bicpc_pkg::APB_AW-1:0]  paddr,
    input  logic [bicpc_pkg::APB_DW-1:0]  pwdata,
    output logic [bicpc_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);

    import bicpc_pkg::*;

    // Configuration registers.
    cfg_t     rows_cfg_reg;
    cfg_t     cols_cfg_reg;

    // Frame position and running count.
    row_t     row_reg;
    row_t     row_next;
    col_t     col_reg;
    col_t     col_next;
    count_t   count_reg;
    count_t   count_next;

    // Result register.
    logic     out_valid_reg;
    count_t   coast_count_reg;

    // Line store: bit 1 holds the pixel two rows up, bit 0 the pixel one row
    // up, for each column. The read port runs one pixel ahead of the input.
    logic [1:0] line_mem [MAX_COLS];
    logic [1:0] line_q_reg;
    col_t       rd_addr;

    // Three-column window trailing the input by one column. The pixel judged
    // as interior is the one above and to the left of the incoming pixel.
    logic     win_up_reg;      // two rows up, previous column
    logic     win_mid_reg;     // one row up, previous column (the centre)
    logic     win_left_reg;    // one row up, two columns back
    logic     win_down_reg;    // current row, previous column

    logic     in_accept;
    logic     cfg_wr;
    reg_idx_t cfg_idx;
    row_t     row_last;
    col_t     col_last;
    logic     col_end;
    logic     frame_end;
    logic     pix_up;
    logic     pix_above;
    logic     interior_hit;
    logic     border_hit;
    logic [1:0]         inc;
    logic [COUNT_W:0]   sum;

    assign row_last = last_row(rows_cfg_reg);
    assign col_last = last_col(cols_cfg_reg);

    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        case (cfg_idx)
            REG_ROWS: prdata = APB_DW'(rows_cfg_reg);
            REG_COLS: prdata = APB_DW'(cols_cfg_reg);
            default:  prdata = '0;
        endcase
    end

    assign col_end   = (col_reg == col_last);
    assign frame_end = col_end && (row_reg == row_last);

    // Only the last pixel of a frame has to wait for the result slot.
    assign in_ready  = !out_valid_reg || out_ready || !frame_end;
    assign in_accept = in_valid && in_ready;

    assign pix_up    = line_q_reg[1];
    assign pix_above = line_q_reg[0];

    // The centre pixel sits on row_reg-1, column col_reg-1; it is interior
    // when it is at least one row and one column away from every edge.
    assign interior_hit = (int'(row_reg) >= 2) && (int'(col_reg) >= 2) && win_mid_reg
                          && (!win_up_reg || !win_left_reg || !pix_above || !win_down_reg);

    assign border_hit = is_land && ((row_reg == '0) || (row_reg == row_last)
                                    || (col_reg == '0) || col_end);

    assign inc = {1'b0, interior_hit} + {1'b0, border_hit};
    assign sum = {1'b0, count_reg} + (COUNT_W+1)'(inc);

    always_comb
    begin
        if (sum > {1'b0, COUNT_MAX})
        begin
            count_next = COUNT_MAX;
        end
        else
        begin
            count_next = sum[COUNT_W-1:0];
        end

        if (col_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : row_reg + row_t'(1);
        end
        else
        begin
            col_next = col_reg + col_t'(1);
            row_next = row_reg;
        end

        if (cfg_wr)
        begin
            rd_addr = '0;
        end
        else if (in_accept)
        begin
            rd_addr = col_next;
        end
        else
        begin
            rd_addr = col_reg;
        end
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg  <= cfg_t'(1);
            cols_cfg_reg  <= cfg_t'(1);
            row_reg       <= '0;
            col_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_ROWS: rows_cfg_reg <= pwdata[CFG_W-1:0];
                    REG_COLS: cols_cfg_reg <= pwdata[CFG_W-1:0];
                    default:  rows_cfg_reg <= rows_cfg_reg;
                endcase
                row_reg   <= '0;
                col_reg   <= '0;
                count_reg <= '0;
            end
            else if (in_accept)
            begin
                row_reg   <= row_next;
                col_reg   <= col_next;
                count_reg <= frame_end ? '0 : count_next;
            end

            if (in_accept && frame_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Window and result payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            win_up_reg   <= pix_up;
            win_mid_reg  <= pix_above;
            win_left_reg <= win_mid_reg;
            win_down_reg <= is_land;
            if (frame_end)
            begin
                coast_count_reg <= count_next;
            end
        end
    end

    // Line store: the column being consumed is rewritten with the rows
    // shifted down by one.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            line_mem[col_reg] <= {pix_above, is_land};
        end
        line_q_reg <= line_mem[rd_addr];
    end

    assign out_valid   = out_valid_reg;
    assign coast_count = coast_count_reg;

endmodule

// ----- rtl/bicpc_checker.sv -----
// ----------------------------------------------------------------------------
// Coast pixel counter checker
// Port-level assertions on the counter's handshakes and register port.
// ----------------------------------------------------------------------------
module bicpc_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [bicpc_pkg::COUNT_W-1:0] coast_count,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bicpc_pkg::APB_AW-1:0]  paddr,
    input  logic [bicpc_pkg::APB_DW-1:0]  pwdata,
    input  logic [bicpc_pkg::APB_DW-1:0]  prdata,
    input  logic                          pready
);

    import bicpc_pkg::*;

    // A waiting result holds its value.
    property p_result_holds;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(coast_count);
    endproperty
    a_result_holds: assert property (p_result_holds)
        else $error("result changed or vanished while stalled");

    // The input only stalls while a result is waiting to be taken.
    property p_stall_cause;
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready;
    endproperty
    a_stall_cause: assert property (p_stall_cause)
        else $error("input stalled with no result pending");

    // A new result always follows an accepted item.
    property p_result_source;
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready);
    endproperty
    a_result_source: assert property (p_result_source)
        else $error("result appeared without an accepted item");

    // A register reads back what was just written to it.
    property p_reg_readback;
        @(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(psel && penable && pwrite && pready) && (paddr == $past(paddr))
            |-> prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]);
    endproperty
    a_reg_readback: assert property (p_reg_readback)
        else $error("register read-back mismatch");

endmodule

bind binary_image_coast_pixel_count_top bicpc_checker u_bicpc_checker (.*);
